// ===== hdl/lom_pkg.sv =====
`timescale 1ns / 1ps

package lom_pkg;

    // Default number of resting slots on each side of the book.
    localparam int BOOK_DEPTH_DEFAULT = 32;

    localparam int WORD_W    = 32;
    localparam int OUTCOME_W = 2;

    // Result kinds.
    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    // Order sides.
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Acknowledgement outcomes.
    localparam logic [OUTCOME_W-1:0] OUTCOME_RESTED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILLED  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_ZERO    = 2'd3;

endpackage

// ===== hdl/limit_order_matcher_unit.sv =====
`timescale 1ns / 1ps

// Limit order matcher: a two-sided book of BOOK_DEPTH bid and BOOK_DEPTH ask slots.
// A transaction on the input side is accepted at a rising edge with start high and
// busy low; it carries one limit order (side, trader, amount, limit price). The
// order takes the next order number and is matched against the best resting order
// of the other side while the prices cross. Each match produces a trade result, and
// an acknowledgement (o_last high) always ends the run for that order.
// Results appear on the o_ ports for exactly one cycle, marked by o_strobe. The
// receiver cannot stall them; they come at most one per cycle.
// A zero amount is acknowledged in the cycle after acceptance and busy stays
// low. Otherwise busy stays high while the order is matched; the number of book
// scans is T or T+1, where T is the number of trades. Each scan walks the
// resting slots one per cycle through a single shared price/number comparator fed
// by a registered memory read.
// Reset empties both sides (valid bits cleared) and sets the next order number to one.
module limit_order_matcher_unit
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [WORD_W-1:0]    i_trader,
    input  logic [WORD_W-1:0]    i_amount,
    input  logic [WORD_W-1:0]    i_limit_price,
    output logic                 o_strobe,
    output logic                 o_kind,
    output logic [WORD_W-1:0]    o_buy_number,
    output logic [WORD_W-1:0]    o_sell_number,
    output logic [WORD_W-1:0]    o_filled,
    output logic [WORD_W-1:0]    o_assigned_number,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic                 o_last
);

    localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOOK_DEPTH - 1);
    localparam logic [CNT_W-1:0] MAX_TRADES = CNT_W'(BOOK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_TRADE,
        S_FINISH
    } t_state;

    // Book storage. Valid bits live in flip-flops; the payload is in memories.
    logic [BOOK_DEPTH-1:0] r_bid_valid, n_bid_valid;
    logic [BOOK_DEPTH-1:0] r_ask_valid, n_ask_valid;
    logic [WORD_W-1:0] r_bid_price  [BOOK_DEPTH];
    logic [WORD_W-1:0] r_bid_left   [BOOK_DEPTH];
    logic [WORD_W-1:0] r_bid_number [BOOK_DEPTH];
    logic [WORD_W-1:0] r_bid_trader [BOOK_DEPTH];
    logic [WORD_W-1:0] r_ask_price  [BOOK_DEPTH];
    logic [WORD_W-1:0] r_ask_left   [BOOK_DEPTH];
    logic [WORD_W-1:0] r_ask_number [BOOK_DEPTH];
    logic [WORD_W-1:0] r_ask_trader [BOOK_DEPTH];

    // Registered read ports of the memories.
    logic [WORD_W-1:0] r_bid_rd_price, r_bid_rd_left, r_bid_rd_number;
    logic [WORD_W-1:0] r_ask_rd_price, r_ask_rd_left, r_ask_rd_number;

    // Sequencer and working registers for the order in progress.
    t_state            r_state;
    logic [WORD_W-1:0] r_next_number;
    logic              r_is_sell;
    logic [WORD_W-1:0] r_trader;
    logic [WORD_W-1:0] r_left;
    logic [WORD_W-1:0] r_price;
    logic [WORD_W-1:0] r_assigned;
    logic [CNT_W-1:0]  r_trades;
    logic [IDX_W-1:0]  r_addr;
    logic              r_cmp_valid;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [WORD_W-1:0] r_best_price;
    logic [WORD_W-1:0] r_best_left;
    logic [WORD_W-1:0] r_best_number;
    logic              r_take_all;

    // Combinational helpers.
    logic              accept;
    logic [WORD_W-1:0] bumped_number;
    logic [WORD_W-1:0] rd_price, rd_left, rd_number;
    logic              rd_slot_valid;
    logic              better;
    logic              crosses;
    logic [WORD_W-1:0] sub_a, sub_b, diff;
    logic [WORD_W-1:0] trade_qty;
    logic              opp_emptied;
    logic [BOOK_DEPTH-1:0] own_valid;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              insert_we;
    logic              left_we;
    logic [IDX_W-1:0]  left_wa;
    logic [WORD_W-1:0] left_wd;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Order numbers skip zero when they wrap.
    always_comb begin
        bumped_number = r_next_number + WORD_W'(1);
        if (bumped_number == '0) begin
            bumped_number = WORD_W'(1);
        end
    end

    // The opposite side is the one being scanned.
    assign rd_price      = r_is_sell ? r_bid_rd_price  : r_ask_rd_price;
    assign rd_left       = r_is_sell ? r_bid_rd_left   : r_ask_rd_left;
    assign rd_number     = r_is_sell ? r_bid_rd_number : r_ask_rd_number;
    assign rd_slot_valid = r_is_sell ? r_bid_valid[r_cmp_idx] : r_ask_valid[r_cmp_idx];

    // Shared comparator: highest bid or lowest ask, ties to the lowest order number.
    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (rd_price != r_best_price) begin
            better = r_is_sell ? (rd_price > r_best_price) : (rd_price < r_best_price);
        end else begin
            better = rd_number < r_best_number;
        end
    end

    assign crosses = r_is_sell ? (r_best_price >= r_price) : (r_price >= r_best_price);

    // One subtractor settles a trade: either the incoming order is used up, or
    // the resting order is, and the difference goes to the survivor.
    assign sub_a       = r_take_all ? r_best_left : r_left;
    assign sub_b       = r_take_all ? r_left      : r_best_left;
    assign diff        = sub_a - sub_b;
    assign trade_qty   = sub_b;
    assign opp_emptied = !r_take_all || (diff == '0);

    // Lowest free slot on the order's own side.
    assign own_valid = r_is_sell ? r_ask_valid : r_bid_valid;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
            if (!own_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign insert_we = (r_state == S_FINISH) && (r_left != '0) && free_found;

    // Remaining-quantity write port: a partial fill of a resting order, or an insert.
    always_comb begin
        left_we = 1'b0;
        left_wa = free_idx;
        left_wd = r_left;
        if ((r_state == S_TRADE) && r_take_all) begin
            left_we = 1'b1;
            left_wa = r_best_idx;
            left_wd = diff;
        end else if (insert_we) begin
            left_we = 1'b1;
        end
    end

    // Valid bit updates.
    always_comb begin
        n_bid_valid = r_bid_valid;
        n_ask_valid = r_ask_valid;
        if ((r_state == S_TRADE) && opp_emptied) begin
            if (r_is_sell) begin
                n_bid_valid[r_best_idx] = 1'b0;
            end else begin
                n_ask_valid[r_best_idx] = 1'b0;
            end
        end
        if (insert_we) begin
            if (r_is_sell) begin
                n_ask_valid[free_idx] = 1'b1;
            end else begin
                n_bid_valid[free_idx] = 1'b1;
            end
        end
    end

    // Bid side memory.
    always_ff @(posedge i_clk) begin
        if (insert_we && !r_is_sell) begin
            r_bid_price[free_idx]  <= r_price;
            r_bid_number[free_idx] <= r_assigned;
            r_bid_trader[free_idx] <= r_trader;
        end
        if (left_we && !r_is_sell == insert_we) begin
            r_bid_left[left_wa] <= left_wd;
        end
        r_bid_rd_price  <= r_bid_price[r_addr];
        r_bid_rd_left   <= r_bid_left[r_addr];
        r_bid_rd_number <= r_bid_number[r_addr];
    end

    // Ask side memory.
    always_ff @(posedge i_clk) begin
        if (insert_we && r_is_sell) begin
            r_ask_price[free_idx]  <= r_price;
            r_ask_number[free_idx] <= r_assigned;
            r_ask_trader[free_idx] <= r_trader;
        end
        if (left_we && r_is_sell == insert_we) begin
            r_ask_left[left_wa] <= left_wd;
        end
        r_ask_rd_price  <= r_ask_price[r_addr];
        r_ask_rd_left   <= r_ask_left[r_addr];
        r_ask_rd_number <= r_ask_number[r_addr];
    end

    // Sequencer, working registers and the registered result port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_next_number <= WORD_W'(1);
            r_bid_valid   <= '0;
            r_ask_valid   <= '0;
            r_cmp_valid   <= 1'b0;
            r_found       <= 1'b0;
            r_addr        <= '0;
            r_trades      <= '0;
            o_strobe      <= 1'b0;
        end else begin
            r_bid_valid <= n_bid_valid;
            r_ask_valid <= n_ask_valid;
            o_strobe    <= 1'b0;
            r_cmp_valid <= 1'b0;

            // The compare stage uses the read address of the previous cycle.
            if (r_cmp_valid && rd_slot_valid && better) begin
                r_found       <= 1'b1;
                r_best_idx    <= r_cmp_idx;
                r_best_price  <= rd_price;
                r_best_left   <= rd_left;
                r_best_number <= rd_number;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_next_number <= bumped_number;
                        r_is_sell     <= (i_mode == SIDE_SELL);
                        r_trader      <= i_trader;
                        r_left        <= i_amount;
                        r_price       <= i_limit_price;
                        r_assigned    <= r_next_number;
                        r_trades      <= '0;
                        r_addr        <= '0;
                        r_found       <= 1'b0;
                        if (i_amount == '0) begin
                            o_strobe          <= 1'b1;
                            o_kind            <= KIND_ACK;
                            o_buy_number      <= '0;
                            o_sell_number     <= '0;
                            o_filled          <= '0;
                            o_assigned_number <= r_next_number;
                            o_outcome         <= OUTCOME_ZERO;
                            o_last            <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_valid <= 1'b1;
                    r_cmp_idx   <= r_addr;
                    if (r_addr == LAST_IDX) begin
                        r_addr  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_take_all <= (r_left <= r_best_left);
                    if (r_found && crosses) begin
                        r_state <= S_TRADE;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_TRADE: begin
                    o_strobe          <= 1'b1;
                    o_kind            <= KIND_TRADE;
                    o_buy_number      <= r_is_sell ? r_best_number : r_assigned;
                    o_sell_number     <= r_is_sell ? r_assigned : r_best_number;
                    o_filled          <= trade_qty;
                    o_assigned_number <= r_assigned;
                    o_outcome         <= OUTCOME_RESTED;
                    o_last            <= 1'b0;
                    r_left            <= r_take_all ? '0 : diff;
                    r_trades          <= r_trades + CNT_W'(1);
                    r_found           <= 1'b0;
                    r_addr            <= '0;
                    if (!r_take_all && (r_trades + CNT_W'(1) < MAX_TRADES)) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    o_strobe          <= 1'b1;
                    o_kind            <= KIND_ACK;
                    o_buy_number      <= '0;
                    o_sell_number     <= '0;
                    o_filled          <= r_left;
                    o_assigned_number <= r_assigned;
                    o_last            <= 1'b1;
                    priority if (r_left == '0) begin
                        o_outcome <= OUTCOME_FILLED;
                    end else if (free_found) begin
                        o_outcome <= OUTCOME_RESTED;
                    end else begin
                        o_outcome <= OUTCOME_DROPPED;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/tb_limit_order_matcher_unit.sv =====
`timescale 1ns / 1ps

module tb_limit_order_matcher_unit;

    import lom_pkg::*;

    localparam int DEPTH = BOOK_DEPTH_DEFAULT;

    // The longest single order is a full sweep of the opposite side. The quiet
    // period at the end of the run covers that figure with some margin.
    localparam int DRAIN_CYCLES = (DEPTH + 1) * (DEPTH + 3) + 16;

    // The slowest correct run is at most 604 orders of a full sweep each, plus the
    // sender gaps, and this limit lies well above that.
    localparam longint TIMEOUT_NS = 64'd30_000_000;

    // Trade records carry a zero outcome field.
    localparam logic [OUTCOME_W-1:0] OUTCOME_NONE = '0;

    // One limit order waiting to be sent.
    typedef struct {
        logic              side;
        logic [WORD_W-1:0] trader;
        logic [WORD_W-1:0] amount;
        logic [WORD_W-1:0] price;
    } t_order;

    // One trade record or acknowledgement as the block should produce it.
    typedef struct {
        logic                 kind;
        logic [WORD_W-1:0]    buy_number;
        logic [WORD_W-1:0]    sell_number;
        logic [WORD_W-1:0]    filled;
        logic [WORD_W-1:0]    assigned_number;
        logic [OUTCOME_W-1:0] outcome;
        logic                 last;
    } t_book_event;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_mode = SIDE_BUY;
    logic [WORD_W-1:0]    i_trader = '0;
    logic [WORD_W-1:0]    i_amount = '0;
    logic [WORD_W-1:0]    i_limit_price = '0;
    logic                 o_strobe;
    logic                 o_kind;
    logic [WORD_W-1:0]    o_buy_number;
    logic [WORD_W-1:0]    o_sell_number;
    logic [WORD_W-1:0]    o_filled;
    logic [WORD_W-1:0]    o_assigned_number;
    logic [OUTCOME_W-1:0] o_outcome;
    logic                 o_last;

    t_order      pending_orders[$];
    t_book_event expected_events[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;

    // Shadow copy of the book. The first index is the side of the resting
    // orders: SIDE_BUY holds the bids and SIDE_SELL holds the asks. The trader
    // field is never visible at the outputs, so it is not kept here.
    logic              book_live   [2][DEPTH] = '{default: 1'b0};
    logic [WORD_W-1:0] book_price  [2][DEPTH];
    logic [WORD_W-1:0] book_left   [2][DEPTH];
    logic [WORD_W-1:0] book_number [2][DEPTH];
    logic [WORD_W-1:0] next_order_number = 1;

    limit_order_matcher_unit #(
        .BOOK_DEPTH(DEPTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_trader         (i_trader),
        .i_amount         (i_amount),
        .i_limit_price    (i_limit_price),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_buy_number     (o_buy_number),
        .o_sell_number    (o_sell_number),
        .o_filled         (o_filled),
        .o_assigned_number(o_assigned_number),
        .o_outcome        (o_outcome),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Appends one expected result to the scoreboard queue.
    task automatic push_event(input logic kind, input logic [WORD_W-1:0] buy_number,
                              input logic [WORD_W-1:0] sell_number,
                              input logic [WORD_W-1:0] filled,
                              input logic [WORD_W-1:0] assigned_number,
                              input logic [OUTCOME_W-1:0] outcome, input logic last);
        t_book_event ev;
        ev.kind            = kind;
        ev.buy_number      = buy_number;
        ev.sell_number     = sell_number;
        ev.filled          = filled;
        ev.assigned_number = assigned_number;
        ev.outcome         = outcome;
        ev.last            = last;
        expected_events.insert(expected_events.size(), ev);
    endtask

    // Best resting order of one side: the highest bid or the lowest ask, and on
    // equal prices the lowest order number. Returns -1 for an empty side.
    function automatic int best_resting(input logic sd);
        int   best;
        logic better;
        best = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (book_live[sd][i]) begin
                if (best < 0) begin
                    best = i;
                end else begin
                    if (book_price[sd][i] != book_price[sd][best]) begin
                        better = (sd == SIDE_BUY) ? (book_price[sd][i] > book_price[sd][best])
                                                  : (book_price[sd][i] < book_price[sd][best]);
                    end else begin
                        better = book_number[sd][i] < book_number[sd][best];
                    end
                    if (better) begin
                        best = i;
                    end
                end
            end
        end
        return best;
    endfunction

    // Runs one accepted order through the shadow book and queues every trade
    // record it causes, followed by its acknowledgement.
    task automatic predict_order(input logic side, input logic [WORD_W-1:0] amount,
                                 input logic [WORD_W-1:0] price);
        logic [WORD_W-1:0] assigned;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] qty;
        logic              opp;
        logic              crosses;
        int                best;
        int                slot;
        int                trades;
        assigned = next_order_number;
        // Order numbers skip zero when they wrap around.
        next_order_number = next_order_number + 1;
        if (next_order_number == 0) begin
            next_order_number = 1;
        end
        if (amount == 0) begin
            push_event(KIND_ACK, '0, '0, '0, assigned, OUTCOME_ZERO, 1'b1);
            return;
        end
        opp    = ~side;
        left   = amount;
        trades = 0;
        while (left != 0 && trades < DEPTH) begin
            best = best_resting(opp);
            if (best < 0) begin
                break;
            end
            crosses = (side == SIDE_SELL) ? (book_price[opp][best] >= price)
                                          : (price >= book_price[opp][best]);
            if (!crosses) begin
                break;
            end
            qty = (left < book_left[opp][best]) ? left : book_left[opp][best];
            if (side == SIDE_SELL) begin
                push_event(KIND_TRADE, book_number[opp][best], assigned, qty, assigned,
                           OUTCOME_NONE, 1'b0);
            end else begin
                push_event(KIND_TRADE, assigned, book_number[opp][best], qty, assigned,
                           OUTCOME_NONE, 1'b0);
            end
            left = left - qty;
            book_left[opp][best] = book_left[opp][best] - qty;
            if (book_left[opp][best] == 0) begin
                book_live[opp][best] = 1'b0;
            end
            trades++;
        end
        if (left == 0) begin
            push_event(KIND_ACK, '0, '0, '0, assigned, OUTCOME_FILLED, 1'b1);
            return;
        end
        // The remainder goes into the lowest free slot of its own side.
        slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!book_live[side][i]) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            push_event(KIND_ACK, '0, '0, left, assigned, OUTCOME_DROPPED, 1'b1);
        end else begin
            book_live[side][slot]   = 1'b1;
            book_price[side][slot]  = price;
            book_left[side][slot]   = left;
            book_number[side][slot] = assigned;
            push_event(KIND_ACK, '0, '0, left, assigned, OUTCOME_RESTED, 1'b1);
        end
    endtask

    task automatic queue_order(input logic side, input logic [WORD_W-1:0] trader,
                               input logic [WORD_W-1:0] amount,
                               input logic [WORD_W-1:0] price);
        t_order ord;
        ord.side   = side;
        ord.trader = trader;
        ord.amount = amount;
        ord.price  = price;
        pending_orders.insert(pending_orders.size(), ord);
    endtask

    // Random stimulus is built from rounds. Most rounds are a busy market near
    // one price, where orders cross, rest and tie. Every fourth round stacks one
    // side until it overflows and then sweeps it with one large opposite order,
    // which gives the longest runs of trades. The rest is unstructured noise.
    task automatic queue_random_orders(input int target);
        int                added;
        int                round_no;
        int                count;
        logic              side;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] amount;
        int unsigned       pick;
        added    = 0;
        round_no = 0;
        while (added < target) begin
            if (round_no % 4 == 2) begin
                side  = 1'($urandom_range(1));
                count = $urandom_range(36, 34);
                for (int k = 0; k < count; k++) begin
                    queue_order(side, $urandom, $urandom_range(50, 1),
                                (side == SIDE_BUY) ? $urandom_range(2000, 0)
                                                   : $urandom_range(32'hFFFF_FFFF,
                                                                    32'hFFFF_F000));
                end
                queue_order(~side, $urandom, $urandom_range(2000, 1),
                            (side == SIDE_BUY) ? 32'h0 : 32'hFFFF_FFFF);
                added += count + 1;
            end else if ($urandom_range(99) < 70) begin
                base  = $urandom_range(32'hFFFF_FF00, 32'h100);
                count = $urandom_range(16, 8);
                for (int k = 0; k < count; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 5) begin
                        amount = '0;
                    end else if (pick < 10) begin
                        amount = $urandom;
                    end else begin
                        amount = $urandom_range(40, 1);
                    end
                    queue_order(1'($urandom_range(1)), $urandom, amount,
                                base - 4 + $urandom_range(8));
                end
                added += count;
            end else begin
                count = $urandom_range(6, 3);
                for (int k = 0; k < count; k++) begin
                    amount = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
                    queue_order(1'($urandom_range(1)), $urandom, amount, $urandom);
                end
                added += count;
            end
            round_no++;
        end
    endtask

    task automatic wait_orders_taken();
        do begin
            @(posedge i_clk);
        end while (pending_orders.size() != 0 || start);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Driver. A transaction is accepted at an edge where start is high and busy
    // is low, and the prediction for it is made at that same edge from the values
    // still on the ports. The next order may follow at once, so start is driven
    // exactly once per edge. While busy is high an offered order is held steady.
    always @(posedge i_clk) begin : drive_orders
        t_order nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_order(i_mode, i_amount, i_limit_price);
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_orders.size() != 0
                         && $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_orders.pop_front();
                start         <= 1'b1;
                i_mode        <= nxt.side;
                i_trader      <= nxt.trader;
                i_amount      <= nxt.amount;
                i_limit_price <= nxt.price;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_book_event want;
        if (i_rst_n && o_strobe) begin
            if (expected_events.size() == 0) begin
                $error("unexpected result: kind %0d, assigned number %0d",
                       o_kind, o_assigned_number);
                error_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("kind", WORD_W'(want.kind), WORD_W'(o_kind));
                check_field("buy_number", want.buy_number, o_buy_number);
                check_field("sell_number", want.sell_number, o_sell_number);
                check_field("filled", want.filled, o_filled);
                check_field("assigned_number", want.assigned_number, o_assigned_number);
                check_field("outcome", WORD_W'(want.outcome), WORD_W'(o_outcome));
                check_field("last", WORD_W'(want.last), WORD_W'(o_last));
            end
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: the sender idles about a third of the time.
        sender_idle_pct = 34;

        // Zero quantity on both sides, with all other fields at their extremes.
        queue_order(SIDE_SELL, 32'h0, 32'h0, 32'h0);
        queue_order(SIDE_BUY, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        // A bid at the lowest price and an ask at the highest price do not cross.
        queue_order(SIDE_BUY, 32'h1, 32'd5, 32'h0);
        queue_order(SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A buy at the highest price takes part of the top ask and fills.
        queue_order(SIDE_BUY, 32'h2, 32'd3, 32'hFFFF_FFFF);
        // Three bids at one price are swept in order of their numbers.
        queue_order(SIDE_BUY, 32'h3, 32'd10, 32'd100);
        queue_order(SIDE_BUY, 32'h4, 32'd10, 32'd100);
        queue_order(SIDE_BUY, 32'h5, 32'd7, 32'd100);
        queue_order(SIDE_SELL, 32'h6, 32'd25, 32'd100);
        // A sell takes the leftover bid and rests; a second ask ties with it.
        queue_order(SIDE_SELL, 32'h7, 32'd30, 32'd50);
        queue_order(SIDE_SELL, 32'h8, 32'd4, 32'd50);
        queue_order(SIDE_BUY, 32'h9, 32'd30, 32'd60);
        // A bid one tick below the best ask rests.
        queue_order(SIDE_BUY, 32'hA, 32'd1, 32'd49);
        // A sell at price zero takes every bid and rests the remainder.
        queue_order(SIDE_SELL, 32'hB, 32'd100, 32'h0);
        queue_order(SIDE_BUY, 32'hC, 32'd94, 32'h0);
        queue_order(SIDE_BUY, 32'hD, 32'd2, 32'd50);

        queue_random_orders(160);
        wait_orders_taken();

        // Phase two: the sender idles most of the time.
        sender_idle_pct = 77;
        queue_random_orders(160);
        wait_orders_taken();

        // Phase three: orders are offered back to back.
        sender_idle_pct = 0;
        queue_random_orders(160);

        do begin
            @(posedge i_clk);
        end while (pending_orders.size() != 0 || start || busy
                   || expected_events.size() != 0);
        // Anything the block sends during this quiet period is flagged above.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_events.size() != 0) begin
            $error("%0d expected results never arrived", expected_events.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
